// ===== design/psgc_pkg.sv =====
// Package for the per-source sequence gap checker.
// Holds the request/response payload types, the address code tables and the match result type.
// No dependencies.
package psgc_pkg;

   // Payload widths fixed by the frame format
   localparam int ADDR_W   = 8;
   localparam int SEQ_W    = 8;
   localparam int GROUP_W  = 4;
   localparam int RSP_CNT_W = 32;

   // Address code derivation
   localparam int               ADDR_SHIFT = 2;
   localparam logic [ADDR_W-1:0] HOLD_LOW   = 8'h20;
   localparam logic [ADDR_W-1:0] HOLD_HIGH  = 8'h27;
   localparam logic [ADDR_W-1:0] CLEAR_MASK = 8'hFE;

   // Fixed code table and its group map
   localparam int CODE_TABLE_LEN = 27;

   localparam logic [ADDR_W-1:0] CODE_TABLE [CODE_TABLE_LEN] = '{
      8'h08, 8'h0A, 8'h0C, 8'h0E,
      8'h10, 8'h12, 8'h14, 8'h16,
      8'h18, 8'h1A, 8'h1C, 8'h1E,
      8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27,
      8'h28, 8'h2A, 8'h2C, 8'h2E,
      8'h30, 8'h34, 8'h36
   };

   localparam logic [GROUP_W-1:0] GROUP_TABLE [CODE_TABLE_LEN] = '{
      4'd0,  4'd1,  4'd0,  4'd1,
      4'd2,  4'd3,  4'd2,  4'd3,
      4'd4,  4'd5,  4'd4,  4'd5,
      4'd6,  4'd7,  4'd8,  4'd9,
      4'd6,  4'd7,  4'd8,  4'd9,
      4'd10, 4'd11, 4'd10, 4'd11,
      4'd12, 4'd12, 4'd12
   };

   typedef struct packed {
      logic [ADDR_W-1:0] source_addr_low;
      logic [SEQ_W-1:0]  sequence_number;
   } req_type;

   typedef struct packed {
      logic                 matched;
      logic [GROUP_W-1:0]   group_index;
      logic                 sequence_error;
      logic [RSP_CNT_W-1:0] group_error_count;
   } rsp_type;

   typedef struct packed {
      logic               hit;
      logic [GROUP_W-1:0] group;
   } match_type;

endpackage

// ===== design/per_source_sequence_gap_checker_unit.sv =====
// Per-source sequence gap checker, top level.
// Input register, group state and result register; depends on psgc_pkg and psgc_match.
//
// One request per received frame: the low source address byte selects one of NUM_GROUPS
// source groups through a fixed code table, and the frame's sequence byte is checked
// against that group's last byte plus one. The block takes one request per clock while
// the result register is free or draining, and returns exactly one response per request,
// in order. A request is held in the input register, where the table match, the state
// read and the state update happen, and its response is then presented from the result
// register. Group state is read and written in the same stage, so
// requests that follow each other to the same group see each other's updates. An
// unmatched address returns all-zero fields and leaves every group untouched. Error
// counters are COUNT_BITS wide and wrap; the response shows their low 32 bits.
module per_source_sequence_gap_checker_unit #(
   parameter int NUM_CODES  = 27,
   parameter int NUM_GROUPS = 13,
   parameter int COUNT_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  psgc_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output psgc_pkg::rsp_type rsp_payload
);
   import psgc_pkg::*;

   localparam int GIDX_W = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

   // Input stage
   logic    s1_valid_ff;
   req_type s1_req_ff;

   // Result stage
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   // Group state
   logic [SEQ_W-1:0]      last_seq_ff   [NUM_GROUPS];
   logic [COUNT_BITS-1:0] error_count_ff[NUM_GROUPS];
   logic                  error_flag_ff [NUM_GROUPS];

   match_type             match;
   logic                  advance;
   logic [GIDX_W-1:0]     gidx;
   logic [SEQ_W-1:0]      expected;
   logic                  seq_err;
   logic [COUNT_BITS-1:0] count_in;
   rsp_type               rsp_in;

   // Handshake: the input stage moves on when the result register is free or draining
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   psgc_match #(
      .NUM_CODES (NUM_CODES),
      .NUM_GROUPS(NUM_GROUPS)
   ) u_match (
      .addr (s1_req_ff.source_addr_low),
      .match(match)
   );

   // Sequence check against the selected group
   always_comb begin
      gidx     = GIDX_W'(match.group);
      expected = last_seq_ff[gidx] + SEQ_W'(1);
      seq_err  = (s1_req_ff.sequence_number != expected);
      count_in = seq_err ? error_count_ff[gidx] + COUNT_BITS'(1) : error_count_ff[gidx];
      if (match.hit) begin
         rsp_in.matched           = 1'b1;
         rsp_in.group_index       = match.group;
         rsp_in.sequence_error    = seq_err;
         rsp_in.group_error_count = RSP_CNT_W'(count_in);
      end else begin
         rsp_in = '0;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         s1_req_ff <= req_payload;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // Per-group state update
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int g = 0; g < NUM_GROUPS; g++) begin
            last_seq_ff[g]    <= '0;
            error_count_ff[g] <= '0;
            error_flag_ff[g]  <= 1'b0;
         end
      end else if (advance && match.hit) begin
         last_seq_ff[gidx]    <= s1_req_ff.sequence_number;
         error_count_ff[gidx] <= count_in;
         error_flag_ff[gidx]  <= seq_err;
      end
   end

   // Unmatched responses carry all-zero fields
   a_unmatched_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.matched |->
         rsp_ff.group_index == '0 && !rsp_ff.sequence_error && rsp_ff.group_error_count == '0)
      else $error("unmatched response carries nonzero fields");

   // Error flag of the updated group follows the reported error
   a_flag_follows: assert property (@(posedge clock) disable iff (reset)
      advance && match.hit |=> error_flag_ff[$past(gidx)] == rsp_ff.sequence_error)
      else $error("group error flag disagrees with response");

   // Last byte of the updated group is the request's sequence byte
   a_last_seq: assert property (@(posedge clock) disable iff (reset)
      advance && match.hit |=> last_seq_ff[$past(gidx)] == $past(s1_req_ff.sequence_number))
      else $error("group last sequence not updated");

   // In-order frames leave the counter alone
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      advance && match.hit && !seq_err |=>
         error_count_ff[$past(gidx)] == $past(error_count_ff[gidx]))
      else $error("error counter changed on an in-order frame");

   // A response is produced only when a request leaves the input stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance))
      else $error("response appeared without a request");

endmodule

// ===== design/psgc_match.sv =====
// Address code match for the sequence gap checker.
// Turns the source address byte into a code and finds its group in the fixed tables.
// Depends on psgc_pkg.
module psgc_match #(
   parameter int NUM_CODES  = 27,
   parameter int NUM_GROUPS = 13
) (
   input  logic [psgc_pkg::ADDR_W-1:0] addr,
   output psgc_pkg::match_type         match
);
   import psgc_pkg::*;

   logic [ADDR_W-1:0] shifted;
   logic [ADDR_W-1:0] code;

   // Shift, then clear bit 0 outside the held range
   always_comb begin
      shifted = addr >> ADDR_SHIFT;
      if (shifted < HOLD_LOW || shifted > HOLD_HIGH) begin
         code = shifted & CLEAR_MASK;
      end else begin
         code = shifted;
      end
   end

   // First matching entry wins; groups beyond NUM_GROUPS count as no match
   always_comb begin
      logic found;
      found       = 1'b0;
      match.hit   = 1'b0;
      match.group = '0;
      for (int i = 0; i < CODE_TABLE_LEN; i++) begin
         if (i < NUM_CODES && !found && code == CODE_TABLE[i]) begin
            found = 1'b1;
            if (int'(GROUP_TABLE[i]) < NUM_GROUPS) begin
               match.hit   = 1'b1;
               match.group = GROUP_TABLE[i];
            end
         end
      end
   end

endmodule

// ===== test/psgc_response_checker.sv =====
`timescale 1ns / 1ps
// Response checker for per_source_sequence_gap_checker_unit: watches both channels,
// predicts each response from its own per-group state and compares it field by field.
// Depends on psgc_pkg for the payload types and the fixed code tables.
module psgc_response_checker #(
   parameter int NUM_CODES  = 27,
   parameter int NUM_GROUPS = 13,
   parameter int COUNT_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  psgc_pkg::req_type req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  psgc_pkg::rsp_type rsp_payload,
   output int                fail_count,
   output int                pending_count,
   output int                rsp_count,
   output int                match_count,
   output int                gap_count
);
   import psgc_pkg::*;

   // Per-group view of the block's state
   logic [SEQ_W-1:0]      last_seq  [NUM_GROUPS];
   logic [COUNT_BITS-1:0] err_count [NUM_GROUPS];
   logic                  err_flag  [NUM_GROUPS];

   // Responses owed by the block, oldest first
   rsp_type pending_results [$];

   int fails       = 0;
   int responses   = 0;
   int match_total = 0;
   int gaps        = 0;

   // Address byte to source group; out-of-range groups count as no match
   function automatic match_type lookup_group(input logic [ADDR_W-1:0] addr);
      logic [ADDR_W-1:0] code;
      match_type         m;
      int                scan_len;
      code = addr >> ADDR_SHIFT;
      if (code < HOLD_LOW || code > HOLD_HIGH) begin
         code = code & CLEAR_MASK;
      end
      m = '0;
      scan_len = (NUM_CODES < CODE_TABLE_LEN) ? NUM_CODES : CODE_TABLE_LEN;
      for (int i = 0; i < scan_len; i++) begin
         if (!m.hit && CODE_TABLE[i] == code) begin
            m.hit   = 1'b1;
            m.group = GROUP_TABLE[i];
         end
      end
      if (m.hit && int'(m.group) >= NUM_GROUPS) begin
         m = '0;
      end
      return m;
   endfunction

   // Sequence check of one frame; updates the group state
   function automatic rsp_type predict_frame(input req_type frame);
      match_type        m;
      rsp_type          r;
      logic [SEQ_W-1:0] want_seq;
      logic             gap;
      m = lookup_group(frame.source_addr_low);
      r = '0;
      if (m.hit) begin
         want_seq = last_seq[m.group] + 1'b1;
         gap = (frame.sequence_number != want_seq);
         if (gap) begin
            err_count[m.group] = err_count[m.group] + 1'b1;
            err_flag[m.group]  = 1'b1;
         end else begin
            err_flag[m.group] = 1'b0;
         end
         last_seq[m.group]   = frame.sequence_number;
         r.matched           = 1'b1;
         r.group_index       = m.group;
         r.sequence_error    = gap;
         r.group_error_count = RSP_CNT_W'(err_count[m.group]);
      end
      return r;
   endfunction

   function automatic void check_field(input string field, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
         fails++;
      end
   endfunction

   always @(posedge clock) begin : watch_channels
      rsp_type want;
      if (reset) begin
         for (int g = 0; g < NUM_GROUPS; g++) begin
            last_seq[g]  = '0;
            err_count[g] = '0;
            err_flag[g]  = 1'b0;
         end
         pending_results.delete();
      end else begin
         // response first: it always belongs to an older request
         if (rsp_valid && rsp_ready) begin
            responses++;
            if (pending_results.size() == 0) begin
               $display("%0t: response with no request waiting: expected none, actual %p",
                        $time, rsp_payload);
               fails++;
            end else begin
               want = pending_results.pop_front();
               check_field("matched", 64'(want.matched), 64'(rsp_payload.matched));
               check_field("group_index", 64'(want.group_index),
                           64'(rsp_payload.group_index));
               check_field("sequence_error", 64'(want.sequence_error),
                           64'(rsp_payload.sequence_error));
               check_field("group_error_count", 64'(want.group_error_count),
                           64'(rsp_payload.group_error_count));
               if (want.matched) match_total++;
               if (want.sequence_error) gaps++;
            end
         end
         if (req_valid && req_ready) begin
            pending_results.push_back(predict_frame(req_payload));
         end
      end
      // counters seen by the top are registered, so reads at the edge are stable
      fail_count    <= fails;
      pending_count <= pending_results.size();
      rsp_count     <= responses;
      match_count   <= match_total;
      gap_count     <= gaps;
   end

endmodule

// ===== test/tb_per_source_sequence_gap_checker_unit.sv =====
`timescale 1ns / 1ps
// Testbench top for per_source_sequence_gap_checker_unit: clock, reset, request and
// response drivers and the verdict. Depends on psgc_pkg and psgc_response_checker.
module tb_per_source_sequence_gap_checker_unit;
   import psgc_pkg::*;

   localparam int RANDOM_REQS  = 1925;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int LONG_HOLD    = 300;
   localparam int HOLD_AT      = 600;
   localparam int PAUSE_AT     = 1000;
   localparam int DRAIN_CYCLES = 10;
   localparam int NO_GROUP     = 15;
   localparam int NUM_DIRECTED = 25;

   // Directed requests: {source_addr_low, sequence_number}
   localparam logic [15:0] DIRECTED [NUM_DIRECTED] = '{
      16'h2001,   // first frame after reset, group 0, in order
      16'h0000,   // lowest address, no match
      16'hFFFF,   // highest address and byte, no match
      16'h8005,   // hold range 0x20, group 6, gap
      16'h8701,   // 0x21, group 7
      16'h88FF,   // 0x22, group 8, gap
      16'h8F01,   // 0x23, group 9
      16'h9006,   // 0x24, group 6 again, in order
      16'h9702,   // 0x25, group 7
      16'h9B00,   // 0x26, group 8, byte wraps 0xff -> 0x00
      16'h9F03,   // 0x27, group 9, gap
      16'h2402,   // odd code 0x09 folds onto 0x08, group 0
      16'h2B01,   // group 1
      16'h4300,   // group 2, gap
      16'h4C01,   // odd code folds, group 3
      16'h6001,   // group 4
      16'h6F80,   // group 5, gap
      16'hA001,   // group 10
      16'hAB01,   // group 11
      16'hC001,   // group 12 via 0x30
      16'hD702,   // group 12 via 0x34
      16'hDB03,   // group 12 via 0x36
      16'hC855,   // code 0x32, no match
      16'h1C77,   // code 0x06, no match
      16'hF0AA    // code 0x3c, no match
   };

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   int fail_count;
   int pending_count;
   int rsp_count;
   int match_count;
   int gap_count;

   // Stimulus view of the address map and the next in-order byte per group
   logic [ADDR_W-1:0] group_addrs [16][$];
   logic [ADDR_W-1:0] unmatched_addrs [$];
   int                addr_group [256];
   logic [SEQ_W-1:0]  next_seq [16];
   logic              send_burst;
   logic              recv_burst;

   per_source_sequence_gap_checker_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   psgc_response_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .rsp_count     (rsp_count),
      .match_count   (match_count),
      .gap_count     (gap_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run limit
   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Run stopped at the cycle limit of %0d", cycles);
      $display("[per_source_sequence_gap_checker_unit] ERROR");
      $finish;
   end

   // One request: random idle gap, then hold valid until accepted
   task automatic send_request(input logic [ADDR_W-1:0] addr, input logic [SEQ_W-1:0] seq);
      int gap;
      gap = send_burst ? 0 : $urandom_range(15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_payload <= '{source_addr_low: addr, sequence_number: seq};
      req_valid   <= 1'b1;
      do @(posedge clock); while (!req_ready);
      if (addr_group[addr] != NO_GROUP) next_seq[addr_group[addr]] = seq + 1'b1;
   endtask

   // Response side: random stall per response, one long hold-off
   initial begin
      int stall;
      int taken;
      rsp_ready  = 1'b0;
      recv_burst = 1'b0;
      taken      = 0;
      forever begin
         if (taken % 50 == 0) recv_burst = ($urandom_range(2) == 0);
         if (taken == HOLD_AT) stall = LONG_HOLD;
         else stall = recv_burst ? 0 : $urandom_range(15);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   // Request side and verdict
   initial begin
      int               g;
      int               pick;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] code_v;
      logic [SEQ_W-1:0]  seq;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      send_burst  = 1'b0;

      // address lists per group; even codes outside the hold range also take the odd twin
      for (int a = 0; a < 256; a++) addr_group[a] = NO_GROUP;
      for (int i = 0; i < 16; i++) next_seq[i] = 8'd1;
      for (int i = 0; i < CODE_TABLE_LEN; i++) begin
         for (int v = 0; v < 2; v++) begin
            code_v = CODE_TABLE[i] | ADDR_W'(v);
            if (v == 0 || CODE_TABLE[i] < HOLD_LOW || CODE_TABLE[i] > HOLD_HIGH) begin
               for (int k = 0; k < 4; k++) begin
                  addr = ADDR_W'((code_v << ADDR_SHIFT) | k);
                  addr_group[addr] = int'(GROUP_TABLE[i]);
                  group_addrs[GROUP_TABLE[i]].push_back(addr);
               end
            end
         end
      end
      for (int a = 0; a < 256; a++) begin
         if (addr_group[a] == NO_GROUP) unmatched_addrs.push_back(ADDR_W'(a));
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         send_request(DIRECTED[i][15:8], DIRECTED[i][7:0]);
      end

      // mostly in-order streams per group, then gaps, misses and raw noise
      for (int i = 0; i < RANDOM_REQS; i++) begin
         if (i % 50 == 0) send_burst = ($urandom_range(2) == 0);
         if (i == PAUSE_AT) begin
            // let the block drain completely before going on
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_count != 0) @(posedge clock);
         end
         pick = $urandom_range(99);
         g = $urandom_range(12);
         addr = group_addrs[g][$urandom_range(group_addrs[g].size() - 1)];
         if (pick < 70) begin
            seq = next_seq[g];
         end else if (pick < 85) begin
            seq = SEQ_W'($urandom);
         end else if (pick < 95) begin
            addr = unmatched_addrs[$urandom_range(unmatched_addrs.size() - 1)];
            seq  = SEQ_W'($urandom);
         end else begin
            addr = ADDR_W'($urandom);
            seq  = SEQ_W'($urandom);
         end
         send_request(addr, seq);
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests: %0d matched a source group, %0d of them out of sequence,",
               rsp_count, match_count, gap_count);
      $display("%0d outside the code table, with a long response hold-off and a full drain.",
               rsp_count - match_count);
      if (fail_count == 0) begin
         $display("[per_source_sequence_gap_checker_unit] OK");
      end else begin
         $display("[per_source_sequence_gap_checker_unit] ERROR");
      end
      $finish;
   end

endmodule
